// ----- rtl/core/header_length_checksum_frame_parser_assert.svh -----
// Assertion macros shared by the frame parser checker.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef HEADER_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FPAR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FPAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fpar_pkg.sv -----
// Shared types and constants of the header/length/checksum frame parser.
// No dependencies; imported by every module of the block but the checker.
package fpar_pkg;

  localparam logic [7:0] SYNC_FIRST     = 8'h5A;
  localparam logic [7:0] SYNC_SECOND    = 8'hA5;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd7;
  localparam logic [7:0] LIMIT_CEIL     = 8'd248;
  localparam logic [7:0] MAX_LEN_RESET  = 8'd136;

  // Parser states, one-hot.
  typedef enum logic [2:0] {
    ST_HUNT = 3'b001,
    ST_SYNC = 3'b010,
    ST_BODY = 3'b100
  } fpar_state_t;

  // One request held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } fpar_stage_t;

  // One result item.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       in_body;
    logic [7:0] byte_position;
    logic       frame_end;
    logic       checksum_ok;
    logic       length_error;
  } fpar_result_t;

endpackage

// ----- rtl/core/fpar_in_reg.sv -----
// Input register of the frame parser with its stall generation.
// Depends on fpar_pkg for the stage type.
module fpar_in_reg import fpar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  input  logic        out_free,
  output fpar_stage_t stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  // A held byte that cannot move on blocks the next request.
  assign in_stall = valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (out_free) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

// ----- rtl/core/fpar_step.sv -----
// Per-byte parser: header hunt, length check, running sum and checksum compare.
// Depends on fpar_pkg for states, constants and the result type.
module fpar_step import fpar_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   max_len,
  output fpar_result_t result
);

  fpar_state_t state_r, state_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  low_r, low_nxt;

  logic [7:0]  limit;
  logic [7:0]  total_eff;
  logic [8:0]  pos_p1, pos_p2;
  logic [15:0] got;

  // Limits above the ceiling act as the ceiling so the frame length fits 8 bits.
  assign limit     = (max_len > LIMIT_CEIL) ? LIMIT_CEIL : max_len;
  assign total_eff = (pos_r == 8'd0) ? (rx_byte + FRAME_OVERHEAD) : total_r;
  assign pos_p1    = {1'b0, pos_r} + 9'd1;
  assign pos_p2    = {1'b0, pos_r} + 9'd2;
  assign got       = {rx_byte, low_r};

  // Next state and result for the byte in the input register.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    sum_nxt   = sum_r;
    low_nxt   = low_r;

    result.byte_value    = rx_byte;
    result.in_body       = 1'b0;
    result.byte_position = 8'd0;
    result.frame_end     = 1'b0;
    result.checksum_ok   = 1'b0;
    result.length_error  = 1'b0;

    unique case (state_r)
      ST_HUNT: begin
        state_nxt = (rx_byte == SYNC_FIRST) ? ST_SYNC : ST_HUNT;
      end
      ST_SYNC: begin
        // A second sync-first byte or any other byte restarts the hunt.
        if (rx_byte == SYNC_SECOND) begin
          state_nxt = ST_BODY;
          pos_nxt   = 8'd0;
          total_nxt = 8'd0;
          sum_nxt   = 16'd0;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_BODY: begin
        result.in_body       = 1'b1;
        result.byte_position = pos_r;
        if ((pos_r == 8'd0) && (rx_byte > limit)) begin
          // Oversized length byte drops the frame.
          result.length_error = 1'b1;
          state_nxt = ST_HUNT;
          pos_nxt   = 8'd0;
          total_nxt = 8'd0;
          sum_nxt   = 16'd0;
        end else if (pos_p1 == {1'b0, total_eff}) begin
          // Last checksum byte closes the frame either way.
          result.frame_end   = 1'b1;
          result.checksum_ok = (~sum_r == got);
          state_nxt = ST_HUNT;
          pos_nxt   = 8'd0;
          total_nxt = 8'd0;
          sum_nxt   = 16'd0;
        end else begin
          total_nxt = total_eff;
          if (pos_p2 == {1'b0, total_eff}) begin
            low_nxt = rx_byte;
          end else begin
            sum_nxt = sum_r + {8'd0, rx_byte};
          end
          pos_nxt = pos_p1[7:0];
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= 8'd0;
      total_r <= 8'd0;
      sum_r   <= 16'd0;
      low_r   <= 8'd0;
    end else if (advance) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

// ----- rtl/core/fpar_out_reg.sv -----
// Result register of the frame parser, driving the output channel.
// Depends on fpar_pkg for the result type.
module fpar_out_reg import fpar_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  fpar_result_t result,
  output logic         out_free,
  input  logic         out_stall,
  output logic         out_valid,
  output fpar_result_t out_result
);

  logic         valid_r, valid_nxt;
  fpar_result_t result_r;

  // The register can take a new result when empty or being drained.
  assign out_free = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_free) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- rtl/core/header_length_checksum_frame_parser.sv -----
// Top level of the header/length/checksum frame parser.
// Depends on fpar_pkg, fpar_in_reg, fpar_step and fpar_out_reg.
//
// Usage:
//   Received bytes enter on the in_ channel (in_valid, in_rx_byte, in_stall).
//   Every byte gives exactly one result on the out_ channel: the byte echoed,
//   whether it lies in a frame body, its position from the length byte, the
//   end-of-frame mark with the checksum verdict, and the length error flag.
//   The cfg_ channel writes the largest accepted length byte; cfg_ready is
//   always high and writes are meant to happen while the block is idle.
//   A byte held in the input register is loaded into the result register
//   once that register can take it, and is shown from then on.
//   Throughput: one byte per cycle while out_stall is low; the state update
//   between the input and result registers is computed combinationally.
//   Reset: synchronous, active low; the parser returns to the header hunt,
//   both registers empty, and the length limit returns to 136.
//   Stall: while out_stall holds a result, the held result and the byte in
//   the input register stay put and in_stall rises once both are occupied.
module header_length_checksum_frame_parser import fpar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic       out_in_body,
  output logic [7:0] out_byte_position,
  output logic       out_frame_end,
  output logic       out_checksum_ok,
  output logic       out_length_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]   max_len_r;
  logic         out_free;
  logic         advance;
  fpar_stage_t  stage;
  fpar_result_t step_result;
  fpar_result_t out_result;

  // Length limit register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // The held byte is consumed when the result register can take its result.
  assign advance = stage.valid && out_free;

  fpar_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .out_free   (out_free),
    .stage      (stage)
  );

  fpar_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (stage.data),
    .max_len (max_len_r),
    .result  (step_result)
  );

  fpar_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (step_result),
    .out_free   (out_free),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_byte_value    = out_result.byte_value;
  assign out_in_body       = out_result.in_body;
  assign out_byte_position = out_result.byte_position;
  assign out_frame_end     = out_result.frame_end;
  assign out_checksum_ok   = out_result.checksum_ok;
  assign out_length_error  = out_result.length_error;

endmodule

// ----- rtl/core/fpar_checker.sv -----
// Port-level checker for the frame parser, attached to the top level by bind.
// Depends on header_length_checksum_frame_parser_assert.svh for the macros.
`include "header_length_checksum_frame_parser_assert.svh"

module fpar_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_value,
  input logic       out_in_body,
  input logic [7:0] out_byte_position,
  input logic       out_frame_end,
  input logic       out_checksum_ok,
  input logic       out_length_error
);

  // A stalled result stays valid and keeps its byte value and byte position.
  `FPAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte_value) && $stable(out_byte_position), "stalled result changed")

  // Bytes outside a frame carry no position and no frame flags.
  `FPAR_ASSERT_ALWAYS(a_hunt_clean, !(out_valid && !out_in_body) || (out_byte_position == 8'd0 && !out_frame_end && !out_length_error), "hunt byte carries frame flags")

  // A checksum verdict only comes with the end of a frame.
  `FPAR_ASSERT_ALWAYS(a_ok_at_end, !(out_valid && out_checksum_ok) || out_frame_end, "checksum_ok without frame_end")

  // A length error is flagged on the length byte only.
  `FPAR_ASSERT_ALWAYS(a_len_err_pos, !(out_valid && out_length_error) || (out_in_body && out_byte_position == 8'd0 && !out_frame_end), "length error off the length byte")

  // The shortest frame ends at position six.
  `FPAR_ASSERT_ALWAYS(a_end_pos, !(out_valid && out_frame_end) || (out_in_body && out_byte_position >= 8'd6), "frame end too early")

endmodule

bind header_length_checksum_frame_parser fpar_checker u_fpar_checker (.*);
